FILE: rtl/bsc_pkg.sv
// Shared constants and types for the bencode structure checker.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    localparam int BSC_MAX_DEPTH   = 32;
    localparam int BSC_LENGTH_BITS = 32;
    localparam int BSC_OFFSET_W    = 32;

    localparam logic [BSC_OFFSET_W-1:0] BSC_OFFSET_MAX = '1;

    // verdict codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_LIMIT     = 2'd3;

    // bytes with meaning in the grammar
    localparam logic [7:0] CH_DICT  = 8'h64;  // 'd'
    localparam logic [7:0] CH_LIST  = 8'h6C;  // 'l'
    localparam logic [7:0] CH_INT   = 8'h69;  // 'i'
    localparam logic [7:0] CH_END   = 8'h65;  // 'e'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    typedef struct packed {
        logic push;
        logic pop;
        logic dict;   // kind pushed: 1 dict, 0 list
    } t_stack_op;

    typedef struct packed {
        logic [BSC_OFFSET_W-1:0] end_offset;
        logic [1:0]              status;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/bsc_stack.sv
// Container kind stack: top held in a register, entry below prefetched from memory.
`timescale 1ns / 1ps
`default_nettype none

module bsc_stack #(
    parameter int MAX_DEPTH = bsc_pkg::BSC_MAX_DEPTH,
    parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
    input  wire                  i_clk,
    input  bsc_pkg::t_stack_op   i_op,
    input  wire [DW-1:0]         i_depth,
    input  wire [DW-1:0]         i_depth_next,
    output logic                 o_top_dict
);
    import bsc_pkg::*;

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic          r_mem [MAX_DEPTH];
    logic          r_top;
    logic          r_below;
    logic [DW-1:0] rd_full;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_addr = i_depth[AW-1:0];
    // entry just under the top once this transaction settles
    assign rd_full = i_depth_next - DW'(2);
    assign rd_addr = rd_full[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[wr_addr] <= i_op.dict;
        end
        r_below <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_top <= i_op.dict;
        end else if (i_op.pop) begin
            r_top <= r_below;
        end
    end

    assign o_top_dict = r_top;

endmodule

`default_nettype wire

FILE: rtl/bsc_parser.sv
// Parse state, counters and per-byte next-state logic of the checker.
`timescale 1ns / 1ps
`default_nettype none

module bsc_parser #(
    parameter int MAX_DEPTH   = bsc_pkg::BSC_MAX_DEPTH,
    parameter int LENGTH_BITS = bsc_pkg::BSC_LENGTH_BITS,
    parameter int DW          = $clog2(MAX_DEPTH + 1)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire [7:0]            i_byte,
    input  wire                  i_last,
    input  wire                  i_top_dict,
    output bsc_pkg::t_stack_op   o_op,
    output logic [DW-1:0]        o_depth,
    output logic [DW-1:0]        o_depth_next,
    output bsc_pkg::t_result     o_result
);
    import bsc_pkg::*;

    localparam int LB = LENGTH_BITS;

    localparam logic [3:0] PH_VAL    = 4'd0;
    localparam logic [3:0] PH_ITEM   = 4'd1;
    localparam logic [3:0] PH_LEN    = 4'd2;
    localparam logic [3:0] PH_KEYLEN = 4'd3;
    localparam logic [3:0] PH_STR    = 4'd4;
    localparam logic [3:0] PH_KEYSTR = 4'd5;
    localparam logic [3:0] PH_INT    = 4'd6;
    localparam logic [3:0] PH_DONE   = 4'd7;
    localparam logic [3:0] PH_BAD    = 4'd8;
    localparam logic [3:0] PH_LIMIT  = 4'd9;

    logic [3:0]              r_phase,  n_phase;
    logic [DW-1:0]           r_depth,  n_depth;
    logic [LB-1:0]           r_rem,    n_rem;
    logic [BSC_OFFSET_W-1:0] r_off,    n_off;
    logic [BSC_OFFSET_W-1:0] r_vend,   n_vend;

    logic          is_digit;
    logic [LB-1:0] digit;
    logic [LB+3:0] len_mul;
    logic          len_ovf;
    logic [LB-1:0] rem_dec;
    logic          do_start;
    logic          do_finish;
    logic [DW-1:0] fin_depth;
    t_stack_op     op;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = LB'(i_byte[3:0]);
    assign len_mul  = ({4'b0, r_rem} << 3) + ({4'b0, r_rem} << 1) + {4'b0, digit};
    assign len_ovf  = (len_mul[LB+3:LB] != 4'b0);
    assign rem_dec  = r_rem - LB'(r_rem != '0);

    always_comb begin
        n_phase   = r_phase;
        n_depth   = r_depth;
        n_rem     = r_rem;
        n_vend    = r_vend;
        do_start  = 1'b0;
        do_finish = 1'b0;
        fin_depth = r_depth;
        op        = '0;

        unique case (r_phase)
            PH_VAL: begin
                do_start = 1'b1;
            end
            PH_ITEM: begin
                if (r_depth == '0) begin
                    n_phase = PH_BAD;
                end else if (i_byte == CH_END) begin
                    op.pop    = 1'b1;
                    fin_depth = r_depth - DW'(1);
                    n_depth   = fin_depth;
                    do_finish = 1'b1;
                end else if (!i_top_dict) begin
                    do_start = 1'b1;
                end else if (is_digit) begin
                    n_rem   = digit;
                    n_phase = PH_KEYLEN;
                end else if (i_byte == CH_COLON) begin
                    // empty key with no length digits
                    n_rem   = '0;
                    n_phase = PH_VAL;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_LEN, PH_KEYLEN: begin
                if (is_digit) begin
                    if (len_ovf) begin
                        n_phase = PH_LIMIT;
                    end else begin
                        n_rem = len_mul[LB-1:0];
                    end
                end else if (i_byte == CH_COLON) begin
                    if (r_rem != '0) begin
                        n_phase = (r_phase == PH_KEYLEN) ? PH_KEYSTR : PH_STR;
                    end else if (r_phase == PH_KEYLEN) begin
                        n_phase = PH_VAL;
                    end else begin
                        do_finish = 1'b1;
                    end
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_STR, PH_KEYSTR: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    if (r_phase == PH_KEYSTR) begin
                        n_phase = PH_VAL;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_INT: begin
                if (i_byte == CH_END) begin
                    do_finish = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_start) begin
            if ((i_byte == CH_DICT) || (i_byte == CH_LIST)) begin
                if (r_depth == DW'(MAX_DEPTH)) begin
                    n_phase = PH_LIMIT;
                end else begin
                    op.push = 1'b1;
                    op.dict = (i_byte == CH_DICT);
                    n_depth = r_depth + DW'(1);
                    n_phase = PH_ITEM;
                end
            end else if (i_byte == CH_INT) begin
                n_phase = PH_INT;
            end else if (is_digit) begin
                n_rem   = digit;
                n_phase = PH_LEN;
            end else begin
                n_phase = PH_BAD;
            end
        end

        if (do_finish) begin
            if (fin_depth == '0) begin
                if (r_off == BSC_OFFSET_MAX) begin
                    n_phase = PH_LIMIT;
                end else begin
                    n_vend  = r_off + BSC_OFFSET_W'(1);
                    n_phase = PH_DONE;
                end
            end else begin
                n_phase = PH_ITEM;
            end
        end

        n_off = (r_off == BSC_OFFSET_MAX) ? r_off : r_off + BSC_OFFSET_W'(1);

        o_result.end_offset = '0;
        if (n_phase == PH_DONE) begin
            o_result.status     = ST_OK;
            o_result.end_offset = n_vend;
        end else if (n_phase == PH_BAD) begin
            o_result.status = ST_MALFORMED;
        end else if (n_phase == PH_LIMIT) begin
            o_result.status = ST_LIMIT;
        end else begin
            o_result.status = ST_TRUNCATED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VAL;
            r_depth <= '0;
            r_rem   <= '0;
            r_off   <= '0;
            r_vend  <= '0;
        end else if (i_fire) begin
            if (i_last) begin
                // message over: back to the start for the next one
                r_phase <= PH_VAL;
                r_depth <= '0;
                r_rem   <= '0;
                r_off   <= '0;
                r_vend  <= '0;
            end else begin
                r_phase <= n_phase;
                r_depth <= n_depth;
                r_rem   <= n_rem;
                r_off   <= n_off;
                r_vend  <= n_vend;
            end
        end
    end

    assign o_op         = i_fire ? op : '0;
    assign o_depth      = r_depth;
    assign o_depth_next = !i_fire ? r_depth : (i_last ? '0 : n_depth);

endmodule

`default_nettype wire

FILE: rtl/bencode_structure_checker_top.sv
// Top level of the bencode structure checker: input and result registers around the parser.
`timescale 1ns / 1ps
`default_nettype none

// Checks that a bencoded message, fed one byte per transaction with tlast on
// its final byte, starts with one well-formed value (dict, list, integer or
// string); bytes after that value are ignored. One result per message leaves
// on the master side: status 0 well formed, 1 malformed, 2 truncated, 3 nesting,
// length or offset limit exceeded, and the end offset of the first value when
// well formed. Throughput is one byte per clock cycle while the input is not held;
// a byte goes through an input register, is parsed against the phase, counters
// and the stack top (held in a register, with the entry below prefetched from
// the container memory), and the verdict is registered in the result register.
// Input is taken while a result waits downstream; only a last byte whose result
// slot is still full holds the input.
module bencode_structure_checker_top #(
    parameter int MAX_DEPTH   = bsc_pkg::BSC_MAX_DEPTH,
    parameter int LENGTH_BITS = bsc_pkg::BSC_LENGTH_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // [1:0] status, [33:2] end_offset, [39:34] zero
);
    import bsc_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic          fire;
    logic          top_dict;
    t_stack_op     op;
    logic [DW-1:0] depth;
    logic [DW-1:0] depth_next;
    t_result       result;

    assign fire          = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    bsc_parser #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LENGTH_BITS (LENGTH_BITS),
        .DW          (DW)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_top_dict   (top_dict),
        .o_op         (op),
        .o_depth      (depth),
        .o_depth_next (depth_next),
        .o_result     (result)
    );

    bsc_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .DW        (DW)
    ) u_stack (
        .i_clk        (i_clk),
        .i_op         (op),
        .i_depth      (depth),
        .i_depth_next (depth_next),
        .o_top_dict   (top_dict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.end_offset, r_out.status};

endmodule

`default_nettype wire

FILE: tb/sv/tb_bencode_structure_checker_top.sv
// Self-checking testbench for the bencode structure checker top level.
`timescale 1ns / 1ps

module tb_bencode_structure_checker_top;
    import bsc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [3:0] {
        PS_VALUE, PS_ITEM, PS_LEN, PS_KEYLEN, PS_STR, PS_KEYSTR,
        PS_INT, PS_DONE, PS_BAD, PS_LIMIT
    } parse_phase_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [1:0] status, [33:2] end_offset, [39:34] zero

    bencode_structure_checker_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // parser shadow state
    parse_phase_e ps;
    logic         kind_is_dict [BSC_MAX_DEPTH];
    int unsigned  depth;
    logic [31:0]  str_left;
    logic [31:0]  byte_pos;
    logic [31:0]  first_end;

    t_result     verdict_q [$];
    t_result     want, got;
    logic [7:0]  msg_buf [$];
    int          err_count;
    int          bytes_sent;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_pending;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void clear_parser();
        foreach (kind_is_dict[k]) kind_is_dict[k] = 1'b0;
        ps        = PS_VALUE;
        depth     = 0;
        str_left  = '0;
        byte_pos  = '0;
        first_end = '0;
    endfunction

    function automatic void close_value();
        if (depth == 0) begin
            if (byte_pos == BSC_OFFSET_MAX) begin
                ps = PS_LIMIT;
            end else begin
                first_end = byte_pos + 1;
                ps = PS_DONE;
            end
        end else begin
            ps = PS_ITEM;
        end
    endfunction

    function automatic void open_value(logic [7:0] b);
        if (b == CH_DICT || b == CH_LIST) begin
            if (depth >= BSC_MAX_DEPTH) begin
                ps = PS_LIMIT;
            end else begin
                kind_is_dict[depth] = (b == CH_DICT);
                depth++;
                ps = PS_ITEM;
            end
        end else if (b == CH_INT) begin
            ps = PS_INT;
        end else if (is_digit(b)) begin
            str_left = b - CH_ZERO;
            ps = PS_LEN;
        end else begin
            ps = PS_BAD;
        end
    endfunction

    function automatic void length_digit(logic [7:0] b, bit key);
        logic [63:0] v;
        if (is_digit(b)) begin
            v = {32'd0, str_left} * 64'd10 + {56'd0, b - CH_ZERO};
            if (v > ((64'd1 << BSC_LENGTH_BITS) - 64'd1)) ps = PS_LIMIT;
            else str_left = v[31:0];
        end else if (b == CH_COLON) begin
            if (str_left != 0) ps = key ? PS_KEYSTR : PS_STR;
            else if (key) ps = PS_VALUE;
            else close_value();
        end else begin
            ps = PS_BAD;
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        case (ps)
            PS_VALUE: open_value(b);
            PS_ITEM: begin
                if (depth == 0 || depth > BSC_MAX_DEPTH) begin
                    ps = PS_BAD;
                end else if (b == CH_END) begin
                    depth--;
                    close_value();
                end else if (!kind_is_dict[depth-1]) begin
                    open_value(b);
                end else if (is_digit(b)) begin
                    str_left = b - CH_ZERO;
                    ps = PS_KEYLEN;
                end else if (b == CH_COLON) begin
                    // key without length digits: empty key
                    str_left = '0;
                    ps = PS_VALUE;
                end else begin
                    ps = PS_BAD;
                end
            end
            PS_LEN:    length_digit(b, 1'b0);
            PS_KEYLEN: length_digit(b, 1'b1);
            PS_STR, PS_KEYSTR: begin
                if (str_left != 0) str_left--;
                if (str_left == 0) begin
                    if (ps == PS_KEYSTR) ps = PS_VALUE;
                    else close_value();
                end
            end
            PS_INT: if (b == CH_END) close_value();
            default: ;
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b, bit last);
        t_result r;
        parse_byte(b);
        if (byte_pos != BSC_OFFSET_MAX) byte_pos++;
        if (last) begin
            r.end_offset = '0;
            case (ps)
                PS_DONE: begin
                    r.status     = ST_OK;
                    r.end_offset = first_end;
                end
                PS_BAD:   r.status = ST_MALFORMED;
                PS_LIMIT: r.status = ST_LIMIT;
                default:  r.status = ST_TRUNCATED;
            endcase
            verdict_q.push_back(r);
            clear_parser();
        end
    endfunction

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    // result checker: the transaction completes at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[33:0];
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("unexpected result tdata=%h", m_axis_tdata));
            end else begin
                want = verdict_q.pop_front();
                if (got.status != want.status)
                    flag_error($sformatf("status expected %0d actual %0d",
                                         want.status, got.status));
                if (got.end_offset != want.end_offset)
                    flag_error($sformatf("end_offset expected %0d actual %0d",
                                         want.end_offset, got.end_offset));
                if (m_axis_tdata[39:34] != '0)
                    flag_error($sformatf("pad bits expected 0 actual %h",
                                         m_axis_tdata[39:34]));
            end
        end
    end

    // result-side ready, with a long hold-off on request
    initial begin : rx_ready_gen
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // call at a rising edge; leaves tvalid up for a following byte
    task automatic send_byte(logic [7:0] b, bit last);
        bit rdy;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        bytes_sent++;
        predict_byte(b, last);
    endtask

    task automatic send_msg();
        for (int k = 0; k < msg_buf.size(); k++)
            send_byte(msg_buf[k], k == msg_buf.size() - 1);
    endtask

    task automatic send_text(string s);
        msg_buf.delete();
        for (int k = 0; k < s.len(); k++) msg_buf.push_back(s[k]);
        send_msg();
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [7:0] any_but_end();
        logic [7:0] b;
        do b = $urandom; while (b == CH_END);
        return b;
    endfunction

    function automatic void add_string();
        int len;
        len = $urandom_range(0, 12);
        if ($urandom_range(0, 7) == 0) msg_buf.push_back(CH_ZERO);
        if (len >= 10) msg_buf.push_back(CH_ZERO + 8'd1);
        msg_buf.push_back(CH_ZERO + 8'(len % 10));
        msg_buf.push_back(CH_COLON);
        repeat (len) msg_buf.push_back($urandom);
    endfunction

    function automatic void add_value(int lvl);
        int kind;
        int n;
        kind = (lvl >= 3) ? $urandom_range(0, 1) : $urandom_range(0, 3);
        case (kind)
            0: begin
                msg_buf.push_back(CH_INT);
                n = $urandom_range(0, 3);
                repeat (n) msg_buf.push_back(any_but_end());
                msg_buf.push_back(CH_END);
            end
            1: add_string();
            2: begin
                msg_buf.push_back(CH_LIST);
                n = $urandom_range(0, 3);
                repeat (n) add_value(lvl + 1);
                msg_buf.push_back(CH_END);
            end
            default: begin
                msg_buf.push_back(CH_DICT);
                n = $urandom_range(0, 3);
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0) msg_buf.push_back(CH_COLON);
                    else add_string();
                    add_value(lvl + 1);
                end
                msg_buf.push_back(CH_END);
            end
        endcase
    endfunction

    task automatic send_random_msg();
        int n;
        msg_buf.delete();
        add_value(0);
        case ($urandom_range(0, 11))
            0: begin
                n = $urandom_range(1, msg_buf.size());
                while (msg_buf.size() > n) void'(msg_buf.pop_back());
            end
            1: msg_buf[$urandom_range(0, msg_buf.size() - 1)] = $urandom;
            2: repeat ($urandom_range(1, 4)) msg_buf.push_back($urandom);
            3: begin
                n = $urandom_range(28, 34);
                repeat (n) msg_buf.push_front(CH_LIST);
                repeat (n) msg_buf.push_back(CH_END);
            end
            4: begin
                msg_buf.delete();
                msg_buf.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
                repeat ($urandom_range(8, 11))
                    msg_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                msg_buf.push_back(CH_COLON);
                repeat ($urandom_range(0, 3)) msg_buf.push_back($urandom);
            end
            5: begin
                msg_buf.delete();
                msg_buf.push_back($urandom);
            end
            default: ;
        endcase
        send_msg();
    endtask

    task automatic set_idle(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic test_scalar_values();
        send_text("0:");
        send_text("ie");
        msg_buf.delete();
        msg_buf = '{CH_INT, 8'hFF, 8'h00, 8'h2D, CH_END};
        send_msg();
        send_text("03:abc");   // leading zero in length
        send_text("e");        // close at top level
        wait_drain();
    endtask

    task automatic test_containers();
        send_text("le");
        send_text("d:0:e");    // key with no length digits
        send_text("l1:ai7ee");
        send_text("d1:ae");    // close where a dict value is due
        send_text("dxe");      // key starting with neither digit nor colon
        msg_buf.delete();
        msg_buf = '{CH_LIST, 8'hB0, CH_END};   // high byte is no digit
        send_msg();
        wait_drain();
    endtask

    task automatic test_truncation_and_trailing();
        send_text("l1:a");
        send_text("i12");
        send_text("i1exyz");
        wait_drain();
    endtask

    task automatic test_limits();
        // deepest legal nesting, then one level more
        for (int d = BSC_MAX_DEPTH; d <= BSC_MAX_DEPTH + 1; d++) begin
            msg_buf.delete();
            repeat (d) msg_buf.push_back(CH_LIST);
            repeat (d) msg_buf.push_back(CH_END);
            send_msg();
        end
        send_text("4294967295:");
        send_text("4294967296:");
        wait_drain();
    endtask

    task automatic test_random_traffic(int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_random_msg();
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        hold_pending = 1'b1;
        repeat (20) send_text("ie");
        wait_drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        hold_pending  = 1'b0;
        err_count     = 0;
        bytes_sent    = 0;
        set_idle(18, 86);
        clear_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_scalar_values();
        test_containers();
        test_truncation_and_trailing();
        test_limits();
        test_random_traffic(40);
        set_idle(86, 18);
        test_random_traffic(40);
        set_idle(0, 0);
        test_random_traffic(40);
        test_output_backpressure();

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bsc_pkg.sv
rtl/bsc_stack.sv
rtl/bsc_parser.sv
rtl/bencode_structure_checker_top.sv
tb/sv/tb_bencode_structure_checker_top.sv
